@@ design/track2_card_frame_serializer_top_assert.svh @@
// ----------------------------------------------------------------------------
// Track-2 frame serializer assertion macros
// Clocked, reset-qualified property wrappers for the top level.
// ----------------------------------------------------------------------------
`ifndef TRACK2_CARD_FRAME_SERIALIZER_TOP_ASSERT_SVH
`define TRACK2_CARD_FRAME_SERIALIZER_TOP_ASSERT_SVH

// Same-cycle implication.
`define TRK2_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("trk2 same-cycle check failed");

// Next-cycle implication.
`define TRK2_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("trk2 next-cycle check failed");

`endif

@@ design/trk2_pkg.sv @@
// ----------------------------------------------------------------------------
// Track-2 frame serializer package
// Shared widths, defaults, codes and the types passed between modules.
// ----------------------------------------------------------------------------
package trk2_pkg;

    localparam int DIGITS_W        = 32;
    localparam int DIGIT_NIBBLES   = DIGITS_W / 4;
    localparam int TICK_W          = 16;
    localparam int CFG_INDEX_W     = 2;

    localparam int DIGIT_COUNT_DEF = 8;
    localparam int LEAD_ZEROS_DEF  = 10;
    localparam int TRAIL_ZEROS_DEF = 10;

    // Sentinels, LRC: three characters besides the digits
    localparam int CHAR_EXTRA      = 3;
    localparam int BITS_PER_CHAR   = 5;

    localparam logic [3:0] START_SENTINEL = 4'hB;
    localparam logic [3:0] END_SENTINEL   = 4'hF;

    localparam int          SUB_W    = 3;
    localparam logic [SUB_W-1:0] SUB_PARITY = 3'd4;

    localparam logic [TICK_W-1:0] LEAD_DELAY_RST = 16'd500;
    localparam logic [TICK_W-1:0] CLOCK_LOW_RST  = 16'd2;
    localparam logic [TICK_W-1:0] CLOCK_HIGH_RST = 16'd1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LEAD_DELAY = 2'd0,
        CFG_CLOCK_LOW  = 2'd1,
        CFG_CLOCK_HIGH = 2'd2
    } t_cfg_index;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_LEAD = 4'b0010,
        PH_LOW  = 4'b0100,
        PH_HIGH = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [TICK_W-1:0] lead_delay;
        logic [TICK_W-1:0] clock_low;
        logic [TICK_W-1:0] clock_high;
    } t_cfg;

    typedef struct packed {
        logic clock_line;
        logic data_line;
        logic drive_enable;
        logic busy;
        logic done;
    } t_result;

endpackage

@@ design/trk2_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Track-2 configuration registers
// Holds lead delay and clock low/high tick counts, written by index.
// ----------------------------------------------------------------------------
module trk2_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [trk2_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [trk2_pkg::TICK_W-1:0]      i_cfg_data,
    output trk2_pkg::t_cfg                   o_cfg
);
    import trk2_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LEAD_DELAY: n_cfg.lead_delay = i_cfg_data;
                CFG_CLOCK_LOW:  n_cfg.clock_low  = i_cfg_data;
                CFG_CLOCK_HIGH: n_cfg.clock_high = i_cfg_data;
                default:        n_cfg = r_cfg;  // drop writes beyond the list
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lead_delay <= LEAD_DELAY_RST;
            r_cfg.clock_low  <= CLOCK_LOW_RST;
            r_cfg.clock_high <= CLOCK_HIGH_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

@@ design/trk2_frame_bit.sv @@
// ----------------------------------------------------------------------------
// Track-2 frame bit selector
// Maps a frame position and its character/bit coordinates to the frame bit.
// ----------------------------------------------------------------------------
module trk2_frame_bit #(
    parameter int DIGIT_COUNT     = trk2_pkg::DIGIT_COUNT_DEF,
    parameter int LEAD_ZERO_BITS  = trk2_pkg::LEAD_ZEROS_DEF,
    parameter int TRAIL_ZERO_BITS = trk2_pkg::TRAIL_ZEROS_DEF,
    localparam int CHAR_COUNT     = DIGIT_COUNT + trk2_pkg::CHAR_EXTRA,
    localparam int FRAME_BITS     = LEAD_ZERO_BITS + trk2_pkg::BITS_PER_CHAR * CHAR_COUNT
                                    + TRAIL_ZERO_BITS,
    localparam int POS_W          = $clog2(FRAME_BITS),
    localparam int CHAR_W         = $clog2(CHAR_COUNT + 1)
) (
    input  logic [trk2_pkg::DIGITS_W-1:0] i_digits,
    input  logic [3:0]                    i_lrc,
    input  logic [POS_W-1:0]              i_pos,
    input  logic [CHAR_W-1:0]             i_char,
    input  logic [trk2_pkg::SUB_W-1:0]    i_sub,
    output logic                          o_bit
);
    import trk2_pkg::*;

    localparam int CHAR_SLOTS = 2 ** CHAR_W;

    logic [3:0] w_chars [CHAR_SLOTS];
    logic [3:0] w_char;
    logic       w_in_chars;

    // Character table: start sentinel, digits most significant first,
    // end sentinel, LRC; unused slots are zero.
    always_comb begin
        for (int c = 0; c < CHAR_SLOTS; c++) begin
            if (c == 0) begin
                w_chars[c] = START_SENTINEL;
            end else if (c <= DIGIT_COUNT) begin
                if (DIGIT_COUNT - c < DIGIT_NIBBLES) begin
                    w_chars[c] = i_digits[4*(DIGIT_COUNT-c) +: 4];
                end else begin
                    w_chars[c] = 4'h0;
                end
            end else if (c == DIGIT_COUNT + 1) begin
                w_chars[c] = END_SENTINEL;
            end else if (c == DIGIT_COUNT + 2) begin
                w_chars[c] = i_lrc;
            end else begin
                w_chars[c] = 4'h0;
            end
        end
    end

    assign w_char     = w_chars[i_char];
    assign w_in_chars = (i_pos >= POS_W'(LEAD_ZERO_BITS)) && (i_char < CHAR_W'(CHAR_COUNT));

    always_comb begin
        if (!w_in_chars) begin
            o_bit = 1'b0;
        end else if (i_sub == SUB_PARITY) begin
            o_bit = ~^w_char;   // odd parity
        end else begin
            o_bit = w_char[i_sub[1:0]];
        end
    end

endmodule

@@ design/trk2_sequencer.sv @@
// ----------------------------------------------------------------------------
// Track-2 frame sequencer
// Steps the frame state once per accepted item and forms the next result.
// ----------------------------------------------------------------------------
module trk2_sequencer #(
    parameter int DIGIT_COUNT     = trk2_pkg::DIGIT_COUNT_DEF,
    parameter int LEAD_ZERO_BITS  = trk2_pkg::LEAD_ZEROS_DEF,
    parameter int TRAIL_ZERO_BITS = trk2_pkg::TRAIL_ZEROS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_op,
    input  logic [trk2_pkg::DIGITS_W-1:0] i_card_digits,
    input  trk2_pkg::t_cfg                i_cfg,
    output trk2_pkg::t_result             o_result
);
    import trk2_pkg::*;

    localparam int CHAR_COUNT = DIGIT_COUNT + CHAR_EXTRA;
    localparam int FRAME_BITS = LEAD_ZERO_BITS + BITS_PER_CHAR * CHAR_COUNT + TRAIL_ZERO_BITS;
    localparam int POS_W      = $clog2(FRAME_BITS);
    localparam int CHAR_W     = $clog2(CHAR_COUNT + 1);

    logic [DIGITS_W-1:0] r_digits, n_digits;
    logic [3:0]          r_lrc,    n_lrc;
    logic [POS_W-1:0]    r_pos,    n_pos;
    logic [CHAR_W-1:0]   r_char,   n_char;
    logic [SUB_W-1:0]    r_sub,    n_sub;
    t_phase              r_phase,  n_phase;
    logic [TICK_W-1:0]   r_tick,   n_tick;
    logic                r_clock,  n_clock;
    logic                r_data,   n_data;
    logic                n_done;

    logic [POS_W-1:0]  w_adv_pos;
    logic [CHAR_W-1:0] w_adv_char;
    logic [SUB_W-1:0]  w_adv_sub;
    logic [POS_W-1:0]  w_sel_pos;
    logic [CHAR_W-1:0] w_sel_char;
    logic [SUB_W-1:0]  w_sel_sub;
    logic              w_bit;
    logic [TICK_W:0]   w_tick_inc;
    logic [3:0]        w_lrc;

    // Advance the frame position by one bit; hold character and sub-bit outside the characters
    always_comb begin
        w_adv_pos  = r_pos + POS_W'(1);
        w_adv_char = r_char;
        w_adv_sub  = r_sub;
        if ((r_pos >= POS_W'(LEAD_ZERO_BITS)) && (r_char < CHAR_W'(CHAR_COUNT))) begin
            if (r_sub == SUB_PARITY) begin
                w_adv_sub  = '0;
                w_adv_char = r_char + CHAR_W'(1);
            end else begin
                w_adv_sub  = r_sub + SUB_W'(1);
            end
        end
    end

    // The lead phase presents bit 0, the high phase the following bit
    assign w_sel_pos  = (r_phase == PH_LEAD) ? '0 : w_adv_pos;
    assign w_sel_char = (r_phase == PH_LEAD) ? '0 : w_adv_char;
    assign w_sel_sub  = (r_phase == PH_LEAD) ? '0 : w_adv_sub;

    trk2_frame_bit #(
        .DIGIT_COUNT     (DIGIT_COUNT),
        .LEAD_ZERO_BITS  (LEAD_ZERO_BITS),
        .TRAIL_ZERO_BITS (TRAIL_ZERO_BITS)
    ) u_frame_bit (
        .i_digits (r_digits),
        .i_lrc    (r_lrc),
        .i_pos    (w_sel_pos),
        .i_char   (w_sel_char),
        .i_sub    (w_sel_sub),
        .o_bit    (w_bit)
    );

    always_comb begin
        w_lrc = START_SENTINEL ^ END_SENTINEL;
        for (int i = 0; i < DIGIT_NIBBLES; i++) begin
            if (i < DIGIT_COUNT) begin
                w_lrc = w_lrc ^ i_card_digits[4*i +: 4];
            end
        end
    end

    assign w_tick_inc = {1'b0, r_tick} + (TICK_W+1)'(1);

    always_comb begin
        n_digits = r_digits;
        n_lrc    = r_lrc;
        n_pos    = r_pos;
        n_char   = r_char;
        n_sub    = r_sub;
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_clock  = r_clock;
        n_data   = r_data;
        n_done   = 1'b0;
        if (i_accept) begin
            if (i_op == OP_START) begin
                if (r_phase == PH_IDLE) begin
                    n_digits = i_card_digits;
                    n_lrc    = w_lrc;
                    n_pos    = '0;
                    n_char   = '0;
                    n_sub    = '0;
                    n_tick   = '0;
                    n_phase  = PH_LEAD;
                end
            end else begin
                unique case (r_phase)
                    PH_IDLE: begin
                        n_phase = PH_IDLE;
                    end
                    PH_LEAD: begin
                        if (r_tick >= i_cfg.lead_delay) begin
                            n_pos   = '0;
                            n_char  = '0;
                            n_sub   = '0;
                            n_data  = ~w_bit;
                            n_clock = 1'b0;
                            n_phase = PH_LOW;
                            n_tick  = '0;
                        end else begin
                            n_tick = w_tick_inc[TICK_W-1:0];
                        end
                    end
                    PH_LOW: begin
                        if (w_tick_inc >= {1'b0, i_cfg.clock_low}) begin
                            n_clock = 1'b1;
                            n_phase = PH_HIGH;
                            n_tick  = '0;
                        end else begin
                            n_tick = w_tick_inc[TICK_W-1:0];
                        end
                    end
                    PH_HIGH: begin
                        if (w_tick_inc >= {1'b0, i_cfg.clock_high}) begin
                            n_tick = '0;
                            if (r_pos != POS_W'(FRAME_BITS - 1)) begin
                                n_pos   = w_adv_pos;
                                n_char  = w_adv_char;
                                n_sub   = w_adv_sub;
                                n_data  = ~w_bit;
                                n_clock = 1'b0;
                                n_phase = PH_LOW;
                            end else begin
                                n_data  = 1'b1;
                                n_clock = 1'b1;
                                n_phase = PH_IDLE;
                                n_done  = 1'b1;
                            end
                        end else begin
                            n_tick = w_tick_inc[TICK_W-1:0];
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_result.clock_line   = n_clock;
        o_result.data_line    = n_data;
        o_result.drive_enable = (n_phase != PH_IDLE);
        o_result.busy         = (n_phase != PH_IDLE);
        o_result.done         = n_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digits <= '0;
            r_lrc    <= '0;
            r_pos    <= '0;
            r_char   <= '0;
            r_sub    <= '0;
            r_phase  <= PH_IDLE;
            r_tick   <= '0;
            r_clock  <= 1'b1;
            r_data   <= 1'b1;
        end else begin
            r_digits <= n_digits;
            r_lrc    <= n_lrc;
            r_pos    <= n_pos;
            r_char   <= n_char;
            r_sub    <= n_sub;
            r_phase  <= n_phase;
            r_tick   <= n_tick;
            r_clock  <= n_clock;
            r_data   <= n_data;
        end
    end

endmodule

@@ design/trk2_out_stage.sv @@
// ----------------------------------------------------------------------------
// Track-2 result register
// Holds one result item; frees itself in the cycle the receiver takes it.
// ----------------------------------------------------------------------------
module trk2_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  trk2_pkg::t_result i_result,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output trk2_pkg::t_result o_result,
    output logic              o_free
);
    import trk2_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_free      = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    always_comb begin
        priority if (i_load) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

@@ design/track2_card_frame_serializer_top.sv @@
// ----------------------------------------------------------------------------
// Track-2 card frame serializer, top level
// Builds a magnetic-stripe style Track-2 frame and clocks it out on ticks.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_in_valid / o_in_ready): each item is either a tick
//    (i_op = 0) or a start (i_op = 1, with eight BCD digits on i_card_digits).
//    A start taken while idle loads the digits and begins the lead delay; a
//    start while a frame is running is ignored and counts as no tick.
//  - Every accepted item yields exactly one result item on the output channel
//    (o_out_valid / i_out_ready): clock and data line levels, drive enable,
//    busy and a one-item done pulse when the frame completes.
//  - The result is registered; it appears in the cycle after acceptance.
//  - Throughput: one item per cycle while the result register has room; the
//    whole state step for an item is one pass through the sequencer between
//    its state registers and the result register.
//  - Stall: the result register keeps its item while i_out_ready is low and
//    o_in_ready drops only while it is full and not being taken.
//  - Configuration (i_cfg_valid / o_cfg_ready, always ready): index 0 lead
//    delay, index 1 low and index 2 high time of the clock, in ticks; write only while idle.
//  - Reset (i_rst_n low, synchronous): idle, lines released at level one,
//    registers back to 500 / 2 / 1, output channel empty. No clearing pass.
// ----------------------------------------------------------------------------
module track2_card_frame_serializer_top #(
    parameter int DIGIT_COUNT     = trk2_pkg::DIGIT_COUNT_DEF,
    parameter int LEAD_ZERO_BITS  = trk2_pkg::LEAD_ZEROS_DEF,
    parameter int TRAIL_ZERO_BITS = trk2_pkg::TRAIL_ZEROS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input item channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_op,
    input  logic [trk2_pkg::DIGITS_W-1:0]    i_card_digits,
    // result item channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_clock_line,
    output logic                             o_data_line,
    output logic                             o_drive_enable,
    output logic                             o_busy_res,
    output logic                             o_done_res,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [trk2_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [trk2_pkg::TICK_W-1:0]      i_cfg_data
);
    import trk2_pkg::*;

    t_cfg    w_cfg;
    t_result w_next_result;
    t_result w_out_result;
    logic    w_free;
    logic    w_accept;
    logic    w_released;

    // Take an item whenever the result register has room for its result
    assign o_in_ready = w_free;
    assign w_accept   = i_in_valid && w_free;

    trk2_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    trk2_sequencer #(
        .DIGIT_COUNT     (DIGIT_COUNT),
        .LEAD_ZERO_BITS  (LEAD_ZERO_BITS),
        .TRAIL_ZERO_BITS (TRAIL_ZERO_BITS)
    ) u_sequencer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_op          (i_op),
        .i_card_digits (i_card_digits),
        .i_cfg         (w_cfg),
        .o_result      (w_next_result)
    );

    trk2_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_accept),
        .i_result    (w_next_result),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_result    (w_out_result),
        .o_free      (w_free)
    );

    assign o_clock_line   = w_out_result.clock_line;
    assign o_data_line    = w_out_result.data_line;
    assign o_drive_enable = w_out_result.drive_enable;
    assign o_busy_res     = w_out_result.busy;
    assign o_done_res     = w_out_result.done;

    // Lines released, not busy, both levels high
    assign w_released = !o_busy_res && !o_drive_enable && o_clock_line && o_data_line;

`include "track2_card_frame_serializer_top_assert.svh"

    // A finished frame leaves the lines released and both levels high
    `TRK2_ASSERT_IMP(a_done_released, o_out_valid && o_done_res, w_released)
    // Any accepted start leaves the block busy in its result
    `TRK2_ASSERT_NEXT(a_start_busy, w_accept && (i_op == OP_START), o_out_valid && o_busy_res)
    // The clock line is only pulled low while a frame is running
    `TRK2_ASSERT_IMP(a_clock_low_busy, o_out_valid && !o_clock_line, o_busy_res)

endmodule
